[design/wmiqr_pkg.sv]
`timescale 1ns / 1ps

package wmiqr_pkg;

	// Default geometry
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int VALUE_BITS_DEF  = 32;

	// Fixed field widths on the stream ports
	localparam int FIELD_W  = 32;
	localparam int S_DATA_W = 2 * FIELD_W;
	localparam int M_DATA_W = 2 * FIELD_W;
	localparam int M_USER_W = 2;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// Broadcast control to every cell of the chain
	typedef struct packed {
		logic ins;  // insert the broadcast sample, cells above it move up one
		logic pop;  // whole chain moves down one toward cell 0
	} cell_ctl_t;

endpackage

[design/wmiqr_cell.sv]
`timescale 1ns / 1ps

module wmiqr_cell #(
	parameter int VALUE_BITS = wmiqr_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  wmiqr_pkg::cell_ctl_t         ctl,
	input  logic                         occupied,
	input  logic signed [VALUE_BITS-1:0] new_value,
	input  logic [wmiqr_pkg::FIELD_W-1:0] new_weight,
	input  logic                         prev_shift,
	input  logic signed [VALUE_BITS-1:0] prev_value,
	input  logic [wmiqr_pkg::FIELD_W-1:0] prev_weight,
	input  logic signed [VALUE_BITS-1:0] next_value,
	input  logic [wmiqr_pkg::FIELD_W-1:0] next_weight,
	output logic                         shift,
	output logic signed [VALUE_BITS-1:0] value,
	output logic [wmiqr_pkg::FIELD_W-1:0] weight
);

	logic signed [VALUE_BITS-1:0]   value_q;
	logic [wmiqr_pkg::FIELD_W-1:0]  weight_q;

	// Strictly greater: a new sample lands after equal values already held
	assign shift  = !occupied || (value_q > new_value);
	assign value  = value_q;
	assign weight = weight_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && shift) begin
			if (prev_shift) begin
				value_q  <= prev_value;
				weight_q <= prev_weight;
			end else begin
				value_q  <= new_value;
				weight_q <= new_weight;
			end
		end else if (ctl.pop) begin
			value_q  <= next_value;
			weight_q <= next_weight;
		end
	end

endmodule

[design/wmiqr_sweep.sv]
`timescale 1ns / 1ps

module wmiqr_sweep #(
	parameter int VALUE_BITS = wmiqr_pkg::VALUE_BITS_DEF,
	parameter int SUM_W      = wmiqr_pkg::FIELD_W + 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          step,
	input  logic signed [VALUE_BITS-1:0]  head_value,
	input  logic [wmiqr_pkg::FIELD_W-1:0] head_weight,
	input  logic [SUM_W-1:0]              total,
	input  logic [SUM_W+1:0]              total3,
	output logic signed [VALUE_BITS-1:0]  q1_value,
	output logic signed [VALUE_BITS-1:0]  q2_value,
	output logic                          hit3
);

	localparam int CMP_W = SUM_W + 2;

	logic [SUM_W-1:0]             run_q;
	logic                         have1_q, have2_q;
	logic signed [VALUE_BITS-1:0] q1_q, q2_q;
	logic [SUM_W-1:0]             run_n;
	logic [CMP_W-1:0]             run4, run2, total_x;
	logic                         hit1, hit2;

	assign run_n   = run_q + SUM_W'(head_weight);
	assign run4    = {run_n, 2'b00};
	assign run2    = {1'b0, run_n, 1'b0};
	assign total_x = CMP_W'(total);
	assign hit1    = run4 >= total_x;
	assign hit2    = run2 >= total_x;
	assign hit3    = step && (run4 >= total3);

	// Reaching 3/4 implies 1/2 and 1/4, so a quartile not yet held is the head
	assign q1_value = have1_q ? q1_q : head_value;
	assign q2_value = have2_q ? q2_q : head_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (clear) begin
			run_q   <= '0;
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (step) begin
			run_q <= run_n;
			if (hit1) begin
				have1_q <= 1'b1;
			end
			if (hit2) begin
				have2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !have1_q && hit1) begin
			q1_q <= head_value;
		end
		if (step && !have2_q && hit2) begin
			q2_q <= head_value;
		end
	end

endmodule

[design/weighted_median_iqr_unit.sv]
`timescale 1ns / 1ps

// Weighted median and interquartile range of one column of samples. While a
// column loads, one request (value, weight) is taken every cycle and placed
// in order into a chain of MAX_SAMPLES cells by insertion; missing samples are
// skipped and samples past capacity are dropped and flagged. After the request
// marked tlast, the chain drains one cell per cycle into a running-sum unit
// until the running weight first reaches three quarters of the total; an empty
// column skips the drain. Input is held off from the tlast request until the
// result enters the output register, which also waits for the previous result
// to be taken. The result sits in that register, so loading of the next column
// can start before it is taken. Stored entries need no clearing after reset or
// between columns.
module weighted_median_iqr_unit #(
	parameter int MAX_SAMPLES = wmiqr_pkg::MAX_SAMPLES_DEF,
	parameter int VALUE_BITS  = wmiqr_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [wmiqr_pkg::S_DATA_W-1:0] s_axis_tdata,  // sample_value, sample_weight
	input  logic                           s_axis_tuser,  // is_missing
	input  logic                           s_axis_tlast,  // last_sample
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [wmiqr_pkg::M_DATA_W-1:0] m_axis_tdata,  // median_value, interquartile_range
	output logic [wmiqr_pkg::M_USER_W-1:0] m_axis_tuser   // column_empty, capacity_exceeded
);

	localparam int FW    = wmiqr_pkg::FIELD_W;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = FW + $clog2(MAX_SAMPLES);
	localparam int EXT_W = (VALUE_BITS > FW) ? VALUE_BITS : FW;

	wmiqr_pkg::state_t    state_q, state_n;
	wmiqr_pkg::cell_ctl_t ctl;

	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  total_q;
	logic [SUM_W+1:0]  total3_q;
	logic              ovf_q;
	logic              empty_q;
	logic [FW-1:0]     med_q, iqr_q;

	logic              accept, room, do_ins;
	logic [EXT_W-1:0]  raw_ext;
	logic signed [VALUE_BITS-1:0] new_value;
	logic [FW-1:0]     new_weight;
	logic [FW+1:0]     weight3;
	logic              out_free;

	logic signed [VALUE_BITS-1:0] cell_value [MAX_SAMPLES];
	logic [FW-1:0]                cell_weight [MAX_SAMPLES];
	logic [MAX_SAMPLES-1:0]       cell_shift;

	logic signed [VALUE_BITS-1:0] q1_value, q2_value;
	logic                         hit3;
	logic signed [EXT_W-1:0]      q1_ext, q2_ext, q3_ext, range_ext;

	assign s_axis_tready = (state_q == wmiqr_pkg::ST_LOAD);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign room          = (cnt_q != CNT_W'(MAX_SAMPLES));
	assign do_ins        = accept && !s_axis_tuser && room;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	assign raw_ext    = EXT_W'(s_axis_tdata[FW-1:0]);
	assign new_value  = raw_ext[VALUE_BITS-1:0];
	assign new_weight = s_axis_tdata[2*FW-1:FW];
	assign weight3    = {1'b0, new_weight, 1'b0} + (FW+2)'(new_weight);

	assign ctl.ins = do_ins;
	assign ctl.pop = (state_q == wmiqr_pkg::ST_SWEEP);

	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		logic                         prev_shift;
		logic signed [VALUE_BITS-1:0] prev_value;
		logic [FW-1:0]                prev_weight;
		logic signed [VALUE_BITS-1:0] next_value;
		logic [FW-1:0]                next_weight;

		if (i == 0) begin : g_first
			assign prev_shift  = 1'b0;
			assign prev_value  = new_value;
			assign prev_weight = new_weight;
		end else begin : g_mid
			assign prev_shift  = cell_shift[i-1];
			assign prev_value  = cell_value[i-1];
			assign prev_weight = cell_weight[i-1];
		end

		if (i == MAX_SAMPLES - 1) begin : g_last
			assign next_value  = cell_value[i];
			assign next_weight = cell_weight[i];
		end else begin : g_inner
			assign next_value  = cell_value[i+1];
			assign next_weight = cell_weight[i+1];
		end

		wmiqr_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (cnt_q > CNT_W'(i)),
			.new_value  (new_value),
			.new_weight (new_weight),
			.prev_shift (prev_shift),
			.prev_value (prev_value),
			.prev_weight(prev_weight),
			.next_value (next_value),
			.next_weight(next_weight),
			.shift      (cell_shift[i]),
			.value      (cell_value[i]),
			.weight     (cell_weight[i])
		);
	end

	wmiqr_sweep #(
		.VALUE_BITS(VALUE_BITS),
		.SUM_W     (SUM_W)
	) u_sweep (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept && s_axis_tlast),
		.step       (ctl.pop),
		.head_value (cell_value[0]),
		.head_weight(cell_weight[0]),
		.total      (total_q),
		.total3     (total3_q),
		.q1_value   (q1_value),
		.q2_value   (q2_value),
		.hit3       (hit3)
	);

	assign q1_ext    = EXT_W'(q1_value);
	assign q2_ext    = EXT_W'(q2_value);
	assign q3_ext    = EXT_W'(cell_value[0]);
	assign range_ext = q3_ext - q1_ext;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			wmiqr_pkg::ST_LOAD: begin
				if (accept && s_axis_tlast) begin
					if (cnt_q == '0 && !do_ins) begin
						state_n = wmiqr_pkg::ST_DONE;
					end else begin
						state_n = wmiqr_pkg::ST_SWEEP;
					end
				end
			end
			wmiqr_pkg::ST_SWEEP: begin
				if (hit3) begin
					state_n = wmiqr_pkg::ST_DONE;
				end
			end
			wmiqr_pkg::ST_DONE: begin
				if (out_free) begin
					state_n = wmiqr_pkg::ST_LOAD;
				end
			end
			default: state_n = wmiqr_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmiqr_pkg::ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			total_q  <= '0;
			total3_q <= '0;
			ovf_q    <= 1'b0;
			empty_q  <= 1'b0;
		end else if (state_q == wmiqr_pkg::ST_DONE) begin
			if (out_free) begin
				cnt_q    <= '0;
				total_q  <= '0;
				total3_q <= '0;
				ovf_q    <= 1'b0;
			end
		end else if (accept) begin
			if (do_ins) begin
				cnt_q    <= cnt_q + CNT_W'(1);
				total_q  <= total_q + SUM_W'(new_weight);
				total3_q <= total3_q + (SUM_W+2)'(weight3);
			end else if (!s_axis_tuser) begin
				ovf_q <= 1'b1;
			end
			if (s_axis_tlast) begin
				empty_q <= (cnt_q == '0) && !do_ins;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_axis_tlast) begin
			med_q <= '0;
			iqr_q <= '0;
		end else if (hit3) begin
			med_q <= q2_ext[FW-1:0];
			iqr_q <= range_ext[FW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == wmiqr_pkg::ST_DONE && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wmiqr_pkg::ST_DONE && out_free) begin
			m_axis_tdata <= {iqr_q, med_q};
			m_axis_tuser <= {ovf_q, empty_q};
		end
	end

endmodule

[sim/weighted_median_iqr_unit_tb.sv]
`timescale 1ns / 1ps

module weighted_median_iqr_unit_tb;

	localparam int MAX_SAMPLES = wmiqr_pkg::MAX_SAMPLES_DEF;
	localparam int RANDOM_SAMPLES = 660;

	typedef struct packed {
		logic [31:0] median;
		logic [31:0] iqr;
		logic        empty;
		logic        dropped;
	} column_result_t;

	typedef enum int {
		VAL_FULL,
		VAL_CLUSTER,
		VAL_EXTREME,
		VAL_POSITIVE
	} value_mix_t;

	typedef enum int {
		WT_FULL,
		WT_TINY,
		WT_ZERO,
		WT_CORNER,
		WT_MODERATE
	} weight_mix_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [wmiqr_pkg::S_DATA_W-1:0]   s_axis_tdata;   // sample_value, sample_weight
	logic                             s_axis_tuser;   // is_missing
	logic                             s_axis_tlast;   // last_sample
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [wmiqr_pkg::M_DATA_W-1:0]   m_axis_tdata;   // median_value, interquartile_range
	logic [wmiqr_pkg::M_USER_W-1:0]   m_axis_tuser;   // column_empty, capacity_exceeded

	// Column being loaded, kept in value order
	logic signed [31:0] held_values[$];
	logic [31:0]        held_weights[$];
	logic [63:0]        held_total;
	bit                 held_dropped;

	column_result_t pending_columns[$];

	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold_req;
	int error_count;
	int requests_sent;
	int columns_checked;
	int empty_checked;
	int dropped_checked;

	weighted_median_iqr_unit #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.VALUE_BITS (wmiqr_pkg::VALUE_BITS_DEF)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Walk the ordered column once; quartile thresholds compared exactly in integers
	function automatic column_result_t weighted_quartiles();
		column_result_t r;
		logic [63:0] run;
		logic signed [31:0] q1, q2, q3;
		bit have1, have2;
		r = '0;
		r.dropped = held_dropped;
		if (held_values.size() == 0) begin
			r.empty = 1'b1;
			return r;
		end
		run = '0;
		have1 = 1'b0;
		have2 = 1'b0;
		q1 = '0;
		q2 = '0;
		q3 = held_values[held_values.size() - 1];
		foreach (held_values[i]) begin
			run += held_weights[i];
			if (!have1 && 4 * run >= held_total) begin
				q1 = held_values[i];
				have1 = 1'b1;
			end
			if (!have2 && 2 * run >= held_total) begin
				q2 = held_values[i];
				have2 = 1'b1;
			end
			if (4 * run >= 3 * held_total) begin
				q3 = held_values[i];
				break;
			end
		end
		r.median = q2;
		r.iqr = q3 - q1;
		return r;
	endfunction

	function automatic void absorb_sample(logic signed [31:0] value, logic [31:0] weight,
			bit missing, bit last);
		int pos;
		if (!missing) begin
			if (held_values.size() < MAX_SAMPLES) begin
				// equal values: new one goes after those already held
				pos = held_values.size();
				while (pos > 0 && held_values[pos - 1] > value)
					pos--;
				held_values.insert(pos, value);
				held_weights.insert(pos, weight);
				held_total += weight;
			end else begin
				held_dropped = 1'b1;
			end
		end
		if (last) begin
			pending_columns.push_back(weighted_quartiles());
			held_values.delete();
			held_weights.delete();
			held_total = '0;
			held_dropped = 1'b0;
		end
	endfunction

	function automatic void check_column();
		column_result_t want;
		if (pending_columns.size() == 0) begin
			error_count++;
			$display("%0t: result with no column pending: tdata=%h tuser=%b",
				$time, m_axis_tdata, m_axis_tuser);
			return;
		end
		want = pending_columns.pop_front();
		columns_checked++;
		if (want.empty)
			empty_checked++;
		if (want.dropped)
			dropped_checked++;
		if (m_axis_tdata[31:0] !== want.median) begin
			error_count++;
			$display("%0t: median_value expected %0d actual %0d", $time,
				$signed(want.median), $signed(m_axis_tdata[31:0]));
		end
		if (m_axis_tdata[63:32] !== want.iqr) begin
			error_count++;
			$display("%0t: interquartile_range expected %h actual %h", $time,
				want.iqr, m_axis_tdata[63:32]);
		end
		if (m_axis_tuser[0] !== want.empty) begin
			error_count++;
			$display("%0t: column_empty expected %b actual %b", $time,
				want.empty, m_axis_tuser[0]);
		end
		if (m_axis_tuser[1] !== want.dropped) begin
			error_count++;
			$display("%0t: capacity_exceeded expected %b actual %b", $time,
				want.dropped, m_axis_tuser[1]);
		end
	endfunction

	// Result sink: one tready update per cycle; stall drawn after each accepted result
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				check_column();
				stall_left = rx_idle_on ? $urandom_range(0, 7) : 0;
			end
			if (rx_hold_req > 0) begin
				stall_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// tvalid is left high after a request so back-to-back requests never toggle it
	task automatic send_sample(logic signed [31:0] value, logic [31:0] weight,
			bit missing, bit last);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {weight, value};
		s_axis_tuser  <= missing;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		absorb_sample(value, weight, missing, last);
		requests_sent++;
	endtask

	task automatic drain_columns();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_columns.size() != 0);
	endtask

	function automatic logic signed [31:0] draw_value(value_mix_t mix);
		logic signed [31:0] v;
		case (mix)
			VAL_FULL: v = $urandom;
			VAL_CLUSTER: v = $signed($urandom_range(0, 8)) - 4;
			VAL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7FFF_FFFF;
					2: v = 32'sh0000_0000;
					default: v = 32'shFFFF_FFFF;
				endcase
			end
			default: v = $urandom_range(0, 32'h0010_0000);
		endcase
		return v;
	endfunction

	function automatic logic [31:0] draw_weight(weight_mix_t mix);
		logic [31:0] w;
		case (mix)
			WT_FULL: w = $urandom;
			WT_TINY: w = $urandom_range(0, 3);
			WT_ZERO: w = '0;
			WT_CORNER: begin
				case ($urandom_range(0, 3))
					0: w = 32'h0000_0000;
					1: w = 32'h0000_0001;
					2: w = 32'h0001_0000;
					default: w = 32'hFFFF_FFFF;
				endcase
			end
			default: w = $urandom_range(0, 32'h0004_0000);
		endcase
		return w;
	endfunction

	task automatic send_column(int length, int missing_pct, value_mix_t vmix,
			weight_mix_t wmix);
		int i;
		for (i = 0; i < length; i++)
			send_sample(draw_value(vmix), draw_weight(wmix),
				$urandom_range(0, 99) < missing_pct, i == length - 1);
	endtask

	task automatic test_directed();
		// empty columns: a lone missing request, then only missing requests
		send_sample(32'sh0001_0000, 32'h0001_0000, 1'b1, 1'b1);
		send_sample(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_sample(32'sh8000_0000, 32'h0000_0000, 1'b1, 1'b0);
		send_sample(32'sh0000_0000, 32'h0000_0001, 1'b1, 1'b1);
		// single sample at the most negative value, heaviest weight
		send_sample(32'sh8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
		// full-scale spread, range wraps to all ones
		send_sample(32'sh7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0);
		send_sample(32'sh8000_0000, 32'h0000_0001, 1'b0, 1'b0);
		send_sample(32'sh0000_0000, 32'h0000_0000, 1'b0, 1'b1);
		// zero total weight: smallest value wins every quartile
		send_sample(32'sh0005_0000, 32'h0000_0000, 1'b0, 1'b0);
		send_sample(-32'sh0003_0000, 32'h0000_0000, 1'b0, 1'b0);
		send_sample(32'sh0007_0000, 32'h0000_0000, 1'b0, 1'b1);
		// equal values, column closed by a missing request
		send_sample(32'sh0002_0000, 32'h0001_0000, 1'b0, 1'b0);
		send_sample(32'sh0002_0000, 32'h0003_0000, 1'b0, 1'b0);
		send_sample(32'sh0001_0000, 32'h0000_0000, 1'b0, 1'b0);
		send_sample(32'sh0009_0000, 32'h0001_0000, 1'b1, 1'b1);
		// heaviest weights everywhere, total needs the wide accumulator
		send_sample(32'sh0004_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_sample(-32'sh0001_8000, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_sample(32'sh0000_4000, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_sample(32'sh0010_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
		drain_columns();
	endtask

	task automatic test_capacity();
		int i;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		// overfilled column: extras past the store are dropped, missing ones ignored
		for (i = 0; i < MAX_SAMPLES; i++)
			send_sample(draw_value(value_mix_t'($urandom_range(0, 3))),
				draw_weight(weight_mix_t'($urandom_range(0, 4))), 1'b0, 1'b0);
		send_sample(draw_value(VAL_FULL), draw_weight(WT_FULL), 1'b1, 1'b0);
		send_sample(draw_value(VAL_FULL), draw_weight(WT_FULL), 1'b0, 1'b0);
		send_sample(draw_value(VAL_FULL), 32'hFFFF_FFFF, 1'b0, 1'b1);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		drain_columns();
	endtask

	task automatic test_pressure();
		int c;
		// sink holds off while short columns keep coming, so the block backs up
		tx_idle_on = 1'b0;
		rx_hold_req = 400;
		for (c = 0; c < 6; c++)
			send_column($urandom_range(2, 8), 10, VAL_CLUSTER, WT_MODERATE);
		tx_idle_on = 1'b1;
		drain_columns();
		send_column(5, 0, VAL_FULL, WT_FULL);
		drain_columns();
	endtask

	task automatic test_random();
		int counted;
		int length;
		int missing_pct;
		int before_count;
		counted = 0;
		while (counted < RANDOM_SAMPLES) begin
			length = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
			case ($urandom_range(0, 15))
				0: missing_pct = 100;
				1, 2: missing_pct = 50;
				3, 4, 5: missing_pct = 0;
				default: missing_pct = 10;
			endcase
			tx_idle_on = $urandom_range(0, 4) != 0;
			rx_idle_on = $urandom_range(0, 4) != 0;
			before_count = requests_sent;
			send_column(length, missing_pct, value_mix_t'($urandom_range(0, 3)),
				weight_mix_t'($urandom_range(0, 4)));
			// all-missing columns are noise and do not count
			if (missing_pct != 100)
				counted += requests_sent - before_count;
			if ($urandom_range(0, 19) == 0)
				drain_columns();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		held_total    = '0;
		held_dropped  = 1'b0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		rx_hold_req   = 0;
		error_count   = 0;
		requests_sent = 0;
		columns_checked = 0;
		empty_checked = 0;
		dropped_checked = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_pressure();
		test_random();

		drain_columns();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests, checked %0d column results", requests_sent,
			columns_checked);
		$display("Covered %0d empty columns and %0d columns with dropped samples",
			empty_checked, dropped_checked);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("%0t: timeout with %0d column results pending", $time,
			pending_columns.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

[weighted_median_iqr_unit.f]
design/wmiqr_pkg.sv
design/wmiqr_cell.sv
design/wmiqr_sweep.sv
design/weighted_median_iqr_unit.sv
sim/weighted_median_iqr_unit_tb.sv
